/* rtl/core/rsi_pkg.sv */
// Shared widths, register codes, reset values and pipeline word types for the sector index block.
package rsi_pkg;

    localparam int CoordW = 16;
    localparam int ExtW   = 15;
    localparam int OrdW   = 20;
    localparam int ShiftW = 4;
    localparam int ColsW  = 11;
    localparam int MapW   = 15;
    localparam int DataW  = 32;
    localparam int AddrW  = 4;
    localparam int DivCells = OrdW;

    localparam logic [1:0] REG_SHIFT   = 2'd0;
    localparam logic [1:0] REG_COLUMNS = 2'd1;
    localparam logic [1:0] REG_MAP_W   = 2'd2;
    localparam logic [1:0] REG_MAP_H   = 2'd3;

    localparam logic [ShiftW-1:0] RST_SHIFT   = 4'd6;
    localparam logic [ColsW-1:0]  RST_COLUMNS = 11'd112;
    localparam logic [MapW-1:0]   RST_MAP_W   = 15'd7168;
    localparam logic [MapW-1:0]   RST_MAP_H   = 15'd4096;

    typedef struct packed {
        logic [ShiftW-1:0] shift;
        logic [ColsW-1:0]  cols;
        logic [MapW-1:0]   map_w;
        logic [MapW-1:0]   map_h;
    } t_cfg;

    typedef struct packed {
        logic [ExtW-1:0] rem;
        logic [OrdW-1:0] dq;
        logic [ExtW-1:0] w;
    } t_div;

    typedef struct packed {
        logic            hit;
        logic            zero;
        logic [OrdW-1:0] base;
        logic [OrdW-1:0] count;
    } t_side;

endpackage

/* rtl/core/rsi_front.sv */
// Front pipeline: snaps and clips the rectangle, forms extents, sector count and base index.
module rsi_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic signed [rsi_pkg::CoordW-1:0]   i_rect_left,
    input  logic signed [rsi_pkg::CoordW-1:0]   i_rect_top,
    input  logic signed [rsi_pkg::CoordW-1:0]   i_rect_right,
    input  logic signed [rsi_pkg::CoordW-1:0]   i_rect_bottom,
    input  logic [rsi_pkg::OrdW-1:0]            i_ordinal,
    input  rsi_pkg::t_cfg                       i_cfg,
    output logic                                o_valid,
    output rsi_pkg::t_div                       o_div,
    output rsi_pkg::t_side                      o_side
);

    logic [3:0] r_vld;

    logic [rsi_pkg::CoordW-1:0] mask;
    logic [rsi_pkg::CoordW-1:0] l_snap;
    logic [rsi_pkg::CoordW-1:0] t_snap;
    logic [rsi_pkg::CoordW-1:0] r_or;
    logic [rsi_pkg::CoordW-1:0] b_or;
    logic signed [rsi_pkg::CoordW:0] r_snap;
    logic signed [rsi_pkg::CoordW:0] b_snap;
    logic signed [rsi_pkg::CoordW:0] map_w_s;
    logic signed [rsi_pkg::CoordW:0] map_h_s;

    logic [rsi_pkg::ExtW-1:0]         n_l_clip;
    logic [rsi_pkg::ExtW-1:0]         n_t_clip;
    logic signed [rsi_pkg::CoordW:0]  n_r_clip;
    logic signed [rsi_pkg::CoordW:0]  n_b_clip;
    logic [rsi_pkg::ExtW-1:0]         r_l_clip;
    logic [rsi_pkg::ExtW-1:0]         r_t_clip;
    logic signed [rsi_pkg::CoordW:0]  r_r_clip;
    logic signed [rsi_pkg::CoordW:0]  r_b_clip;
    logic [rsi_pkg::OrdW-1:0]         r_ord1;

    logic signed [rsi_pkg::CoordW+1:0] dw;
    logic signed [rsi_pkg::CoordW+1:0] dh;
    logic [rsi_pkg::ExtW-1:0]          n_w;
    logic [rsi_pkg::ExtW-1:0]          n_h;
    logic [rsi_pkg::ExtW-1:0]          r_w2;
    logic [rsi_pkg::ExtW-1:0]          r_h2;
    logic [rsi_pkg::ExtW-1:0]          r_lcol2;
    logic [rsi_pkg::ExtW-1:0]          r_trow2;
    logic [rsi_pkg::OrdW-1:0]          r_ord2;

    logic [2*rsi_pkg::ExtW-1:0]             n_count;
    logic [rsi_pkg::ExtW+rsi_pkg::ColsW-1:0] n_rowbase;
    logic [2*rsi_pkg::ExtW-1:0]             r_count3;
    logic [rsi_pkg::ExtW+rsi_pkg::ColsW-1:0] r_rowbase3;
    logic [rsi_pkg::ExtW-1:0]               r_lcol3;
    logic [rsi_pkg::ExtW-1:0]               r_w3;
    logic [rsi_pkg::OrdW-1:0]               r_ord3;

    rsi_pkg::t_div  n_div;
    rsi_pkg::t_side n_side;
    rsi_pkg::t_div  r_div;
    rsi_pkg::t_side r_side;

    assign mask    = rsi_pkg::CoordW'((17'd1 << i_cfg.shift) - 17'd1);
    assign l_snap  = i_rect_left & ~mask;
    assign t_snap  = i_rect_top & ~mask;
    assign r_or    = i_rect_right | mask;
    assign b_or    = i_rect_bottom | mask;
    assign r_snap  = $signed({r_or[rsi_pkg::CoordW-1], r_or}) + 17'sd1;
    assign b_snap  = $signed({b_or[rsi_pkg::CoordW-1], b_or}) + 17'sd1;
    assign map_w_s = $signed({2'b00, i_cfg.map_w});
    assign map_h_s = $signed({2'b00, i_cfg.map_h});

    assign n_l_clip = l_snap[rsi_pkg::CoordW-1] ? '0 : l_snap[rsi_pkg::ExtW-1:0];
    assign n_t_clip = t_snap[rsi_pkg::CoordW-1] ? '0 : t_snap[rsi_pkg::ExtW-1:0];
    assign n_r_clip = (r_snap > map_w_s) ? map_w_s : r_snap;
    assign n_b_clip = (b_snap > map_h_s) ? map_h_s : b_snap;

    assign dw  = $signed({r_r_clip[rsi_pkg::CoordW], r_r_clip}) - $signed({3'b000, r_l_clip});
    assign dh  = $signed({r_b_clip[rsi_pkg::CoordW], r_b_clip}) - $signed({3'b000, r_t_clip});
    assign n_w = (dw > 18'sd0) ? (dw[rsi_pkg::ExtW-1:0] >> i_cfg.shift) : '0;
    assign n_h = (dh > 18'sd0) ? (dh[rsi_pkg::ExtW-1:0] >> i_cfg.shift) : '0;

    assign n_count   = r_w2 * r_h2;
    assign n_rowbase = r_trow2 * i_cfg.cols;

    always_comb begin
        n_div.rem    = '0;
        n_div.dq     = r_ord3;
        n_div.w      = r_w3;
        n_side.hit   = {{(2*rsi_pkg::ExtW-rsi_pkg::OrdW){1'b0}}, r_ord3} < r_count3;
        n_side.zero  = (r_ord3 == '0);
        n_side.base  = r_rowbase3[rsi_pkg::OrdW-1:0]
                     + {{(rsi_pkg::OrdW-rsi_pkg::ExtW){1'b0}}, r_lcol3};
        n_side.count = (|r_count3[2*rsi_pkg::ExtW-1:rsi_pkg::OrdW]) ? '1
                     : r_count3[rsi_pkg::OrdW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_l_clip   <= n_l_clip;
        r_t_clip   <= n_t_clip;
        r_r_clip   <= n_r_clip;
        r_b_clip   <= n_b_clip;
        r_ord1     <= i_ordinal;
        r_w2       <= n_w;
        r_h2       <= n_h;
        r_lcol2    <= r_l_clip >> i_cfg.shift;
        r_trow2    <= r_t_clip >> i_cfg.shift;
        r_ord2     <= r_ord1;
        r_count3   <= n_count;
        r_rowbase3 <= n_rowbase;
        r_lcol3    <= r_lcol2;
        r_w3       <= r_w2;
        r_ord3     <= r_ord2;
        r_div      <= n_div;
        r_side     <= n_side;
    end

    assign o_valid = r_vld[3];
    assign o_div   = r_div;
    assign o_side  = r_side;

endmodule

/* rtl/core/rsi_div_cell.sv */
// One cell of the divider chain: a single restoring step that also forwards the word's side data.
module rsi_div_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  rsi_pkg::t_div   i_div,
    input  rsi_pkg::t_side  i_side,
    output logic            o_valid,
    output rsi_pkg::t_div   o_div,
    output rsi_pkg::t_side  o_side
);

    logic [rsi_pkg::ExtW:0] partial;
    logic [rsi_pkg::ExtW:0] diff;
    logic                   ge;
    rsi_pkg::t_div          n_div;
    logic                   r_valid;
    rsi_pkg::t_div          r_div;
    rsi_pkg::t_side         r_side;

    assign partial = {i_div.rem, i_div.dq[rsi_pkg::OrdW-1]};
    assign ge      = (partial >= {1'b0, i_div.w});
    assign diff    = partial - {1'b0, i_div.w};

    always_comb begin
        n_div.w   = i_div.w;
        n_div.rem = ge ? diff[rsi_pkg::ExtW-1:0] : partial[rsi_pkg::ExtW-1:0];
        n_div.dq  = {i_div.dq[rsi_pkg::OrdW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div  <= n_div;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;
    assign o_side  = r_side;

endmodule

/* rtl/core/rsi_back.sv */
// Back end: turns quotient and remainder into the row-major index and registers the result word.
module rsi_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  rsi_pkg::t_div                   i_div,
    input  rsi_pkg::t_side                  i_side,
    input  logic [rsi_pkg::ColsW-1:0]       i_cols,
    output logic                            o_valid,
    output logic [rsi_pkg::OrdW-1:0]        o_sector_index,
    output logic                            o_found,
    output logic [rsi_pkg::OrdW-1:0]        o_sector_count
);

    logic [rsi_pkg::OrdW+rsi_pkg::ColsW-1:0] qc_full;
    logic [rsi_pkg::OrdW-1:0]                n_sum;
    logic [rsi_pkg::OrdW-1:0]                n_index;

    logic                     r_vld1;
    logic [rsi_pkg::OrdW-1:0] r_qc;
    logic [rsi_pkg::OrdW-1:0] r_sum;
    rsi_pkg::t_side           r_side1;

    logic                     r_vld2;
    logic [rsi_pkg::OrdW-1:0] r_index;
    logic                     r_found;
    logic [rsi_pkg::OrdW-1:0] r_count;

    assign qc_full = i_div.dq * i_cols;
    assign n_sum   = i_side.base + {{(rsi_pkg::OrdW-rsi_pkg::ExtW){1'b0}}, i_div.rem};

    always_comb begin
        if (r_side1.hit) begin
            n_index = r_sum + r_qc;
        end else if (r_side1.zero) begin
            n_index = r_side1.base;
        end else begin
            n_index = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_qc    <= qc_full[rsi_pkg::OrdW-1:0];
        r_sum   <= n_sum;
        r_side1 <= i_side;
        r_index <= n_index;
        r_found <= r_side1.hit | r_side1.zero;
        r_count <= r_side1.count;
    end

    assign o_valid        = r_vld2;
    assign o_sector_index = r_index;
    assign o_found        = r_found;
    assign o_sector_count = r_count;

endmodule

/* rtl/core/rect_sector_index.sv */
// Top level of the sector index block: register port, front pipeline, divider cell chain and back end.
//
// A query word is taken at each rising edge where start is high and busy is low.
// busy stays low, so a new word can be issued in every cycle.
// The word carries a rectangle and an ordinal; the block snaps the rectangle to the
// sector grid, clips it to the map, and returns the ordinal's sector in row-major order.
// Each result word appears on the result ports for exactly one cycle, marked by
// o_result_valid, in query order. Throughput is one word per cycle: four front stages,
// one divider cell per ordinal bit (20 cells, one restoring step each) and two back stages.
// The receiver has no way to stall the pipeline, so words flow through unchecked.
// The user must write registers over the APB-style port only while no query is in flight;
// the block does not enforce this. Shift, column count, map width and map height sit at
// byte addresses 0, 4, 8, 12. Synchronous reset restores the register defaults and
// drops all words in flight.
module rect_sector_index (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [rsi_pkg::CoordW-1:0]   i_rect_left,
    input  logic signed [rsi_pkg::CoordW-1:0]   i_rect_top,
    input  logic signed [rsi_pkg::CoordW-1:0]   i_rect_right,
    input  logic signed [rsi_pkg::CoordW-1:0]   i_rect_bottom,
    input  logic [rsi_pkg::OrdW-1:0]            i_ordinal,
    output logic                                o_result_valid,
    output logic [rsi_pkg::OrdW-1:0]            o_sector_index,
    output logic                                o_found,
    output logic [rsi_pkg::OrdW-1:0]            o_sector_count,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rsi_pkg::AddrW-1:0]           paddr,
    input  logic [rsi_pkg::DataW-1:0]           pwdata,
    output logic [rsi_pkg::DataW-1:0]           prdata,
    output logic                                pready
);

    rsi_pkg::t_cfg  r_cfg;
    logic           cfg_wr;
    logic [1:0]     reg_sel;

    logic           chain_vld  [rsi_pkg::DivCells+1];
    rsi_pkg::t_div  chain_div  [rsi_pkg::DivCells+1];
    rsi_pkg::t_side chain_side [rsi_pkg::DivCells+1];

    assign busy    = 1'b0;
    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.shift <= rsi_pkg::RST_SHIFT;
            r_cfg.cols  <= rsi_pkg::RST_COLUMNS;
            r_cfg.map_w <= rsi_pkg::RST_MAP_W;
            r_cfg.map_h <= rsi_pkg::RST_MAP_H;
        end else if (cfg_wr) begin
            case (reg_sel)
                rsi_pkg::REG_SHIFT:   r_cfg.shift <= pwdata[rsi_pkg::ShiftW-1:0];
                rsi_pkg::REG_COLUMNS: r_cfg.cols  <= pwdata[rsi_pkg::ColsW-1:0];
                rsi_pkg::REG_MAP_W:   r_cfg.map_w <= pwdata[rsi_pkg::MapW-1:0];
                rsi_pkg::REG_MAP_H:   r_cfg.map_h <= pwdata[rsi_pkg::MapW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            rsi_pkg::REG_SHIFT:   prdata = {{(rsi_pkg::DataW-rsi_pkg::ShiftW){1'b0}}, r_cfg.shift};
            rsi_pkg::REG_COLUMNS: prdata = {{(rsi_pkg::DataW-rsi_pkg::ColsW){1'b0}}, r_cfg.cols};
            rsi_pkg::REG_MAP_W:   prdata = {{(rsi_pkg::DataW-rsi_pkg::MapW){1'b0}}, r_cfg.map_w};
            rsi_pkg::REG_MAP_H:   prdata = {{(rsi_pkg::DataW-rsi_pkg::MapW){1'b0}}, r_cfg.map_h};
            default:              prdata = '0;
        endcase
    end

    rsi_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (start & ~busy),
        .i_rect_left   (i_rect_left),
        .i_rect_top    (i_rect_top),
        .i_rect_right  (i_rect_right),
        .i_rect_bottom (i_rect_bottom),
        .i_ordinal     (i_ordinal),
        .i_cfg         (r_cfg),
        .o_valid       (chain_vld[0]),
        .o_div         (chain_div[0]),
        .o_side        (chain_side[0])
    );

    for (genvar g = 0; g < rsi_pkg::DivCells; g++) begin : g_cell
        rsi_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_vld[g]),
            .i_div   (chain_div[g]),
            .i_side  (chain_side[g]),
            .o_valid (chain_vld[g+1]),
            .o_div   (chain_div[g+1]),
            .o_side  (chain_side[g+1])
        );
    end

    rsi_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (chain_vld[rsi_pkg::DivCells]),
        .i_div          (chain_div[rsi_pkg::DivCells]),
        .i_side         (chain_side[rsi_pkg::DivCells]),
        .i_cols         (r_cfg.cols),
        .o_valid        (o_result_valid),
        .o_sector_index (o_sector_index),
        .o_found        (o_found),
        .o_sector_count (o_sector_count)
    );

endmodule
